[hdl/mic_e_pkg.sv]
// Shared types, constants and status codes of the Mic-E position decoder.
package mic_e_pkg;

    localparam int DEST_CHARS_W   = 48;
    localparam int DEST_LENGTH_W  = 6;
    localparam int INFO_BYTES_W   = 64;
    localparam int INFO_LENGTH_W  = 8;
    localparam int S_TDATA_W      = 128;

    localparam int STATUS_W       = 3;
    localparam int LATITUDE_W     = 21;
    localparam int LONGITUDE_W    = 22;
    localparam int SYMBOL_W       = 8;
    localparam int AMBIGUITY_W    = 3;
    localparam int M_TDATA_W      = 72;

    localparam int NUM_DEST_CHARS = 6;
    localparam int NUM_INFO_BYTES = 8;
    localparam int INFO_MIN_LEN   = 8;

    // Scaling into hundredths of an arc minute.
    localparam int DEG_SCALE      = 6000;
    localparam int MIN_SCALE      = 100;
    localparam int HALF_DEGREE    = 3000;
    localparam int HALF_MINUTE    = 50;

    // Longitude byte coding.
    localparam int CHAR_OFFSET    = 28;
    localparam int LON_DEG_OFFSET = 100;
    localparam int LON_WRAP_A_LO  = 180;
    localparam int LON_WRAP_A_HI  = 189;
    localparam int LON_WRAP_A_SUB = 80;
    localparam int LON_WRAP_B_LO  = 190;
    localparam int LON_WRAP_B_HI  = 199;
    localparam int MIN_WRAP       = 60;

    // Destination character thresholds.
    localparam logic [7:0] CH_SOUTH_MAX = 8'h4c;
    localparam logic [7:0] CH_NORTH_MIN = 8'h50;

    // Ambiguity levels.
    localparam logic [2:0] AMB_NONE       = 3'd0;
    localparam logic [2:0] AMB_HUNDREDTHS = 3'd1;
    localparam logic [2:0] AMB_TENTHS     = 3'd2;
    localparam logic [2:0] AMB_MINUTES    = 3'd3;
    localparam logic [2:0] AMB_TEN_MIN    = 3'd4;

    // Digit value that marks an ambiguity character.
    localparam logic [3:0] DIGIT_MARKER = 4'd10;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_SHORT_INFO    = 3'd1,
        ST_BAD_DEST_LEN  = 3'd2,
        ST_BAD_DEST_CHAR = 3'd3,
        ST_BAD_INFO      = 3'd4
    } status_t;

    typedef struct packed {
        logic                            chars_ok;
        logic                            lead_marker;
        logic [AMBIGUITY_W-1:0]          amb;
        logic [NUM_DEST_CHARS-1:0][3:0]  digit;
        logic                            south;
        logic                            lon_offset;
        logic                            west;
    } dest_info_t;

endpackage

[hdl/mic_e_dest.sv]
// Destination call classifier: character checks, digits and ambiguity level.
module mic_e_dest (
    input  logic [mic_e_pkg::DEST_CHARS_W-1:0] dest_chars,
    output mic_e_pkg::dest_info_t              dinfo
);
    import mic_e_pkg::*;

    function automatic logic char_ok(input logic [7:0] c, input logic lead);
        logic digit_ok;
        logic letter_ok;
        digit_ok  = (c >= 8'h30) && (c <= 8'h39);
        letter_ok = lead ? ((c >= 8'h41) && (c <= 8'h4c)) : (c == 8'h4c);
        return digit_ok || letter_ok || ((c >= 8'h50) && (c <= 8'h5a));
    endfunction

    function automatic logic [3:0] char_digit(input logic [7:0] c);
        logic [7:0] d;
        d = {4'd0, DIGIT_MARKER};
        if ((c >= 8'h41) && (c <= 8'h4a)) d = c - 8'h41;
        else if ((c >= 8'h50) && (c <= 8'h59)) d = c - 8'h50;
        else if ((c >= 8'h30) && (c <= 8'h39)) d = c - 8'h30;
        return d[3:0];
    endfunction

    logic [NUM_DEST_CHARS-1:0][7:0] ch;
    logic [NUM_DEST_CHARS-1:0][3:0] raw_digit;
    logic [NUM_DEST_CHARS-1:0]      ok;
    logic [NUM_DEST_CHARS-1:0]      marker;

    always_comb
    begin
        for (int i = 0; i < NUM_DEST_CHARS; i++)
        begin
            ch[i]        = dest_chars[8*(NUM_DEST_CHARS-1-i) +: 8];
            ok[i]        = char_ok(ch[i], i < 3);
            raw_digit[i] = char_digit(ch[i]);
            marker[i]    = (raw_digit[i] == DIGIT_MARKER);
        end
    end

    always_comb
    begin
        dinfo.chars_ok    = &ok;
        dinfo.lead_marker = marker[0] | marker[1];

        // The leftmost marker among characters three to six sets the level.
        if (marker[2])      dinfo.amb = AMB_TEN_MIN;
        else if (marker[3]) dinfo.amb = AMB_MINUTES;
        else if (marker[4]) dinfo.amb = AMB_TENTHS;
        else if (marker[5]) dinfo.amb = AMB_HUNDREDTHS;
        else                dinfo.amb = AMB_NONE;

        dinfo.digit[0] = raw_digit[0];
        dinfo.digit[1] = raw_digit[1];
        dinfo.digit[2] = marker[2] ? 4'd3 : raw_digit[2];
        dinfo.digit[3] = marker[3] ? 4'd5 : raw_digit[3];
        dinfo.digit[4] = marker[4] ? 4'd5 : raw_digit[4];
        dinfo.digit[5] = marker[5] ? 4'd5 : raw_digit[5];

        dinfo.south      = (ch[3] <= CH_SOUTH_MAX);
        dinfo.lon_offset = (ch[4] >= CH_NORTH_MIN);
        dinfo.west       = (ch[5] >= CH_NORTH_MIN);
    end

endmodule

[hdl/mic_e_coord.sv]
// Latitude and longitude arithmetic in hundredths of an arc minute.
module mic_e_coord (
    input  mic_e_pkg::dest_info_t                  dinfo,
    input  logic [7:0]                             lon_deg_byte,
    input  logic [7:0]                             lon_min_byte,
    input  logic [7:0]                             lon_frag_byte,
    output logic signed [mic_e_pkg::LATITUDE_W-1:0]  latitude,
    output logic signed [mic_e_pkg::LONGITUDE_W-1:0] longitude
);
    import mic_e_pkg::*;

    // Clears the units digit of a value below one hundred.
    function automatic logic [6:0] floor10(input logic [6:0] v);
        logic [6:0] r;
        r = 7'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (v >= 7'(k * 10)) r = 7'(k * 10);
        end
        return r;
    endfunction

    logic [6:0]              lat_deg;
    logic [6:0]              lat_min;
    logic [6:0]              lat_frag;
    logic [LATITUDE_W-2:0]   lat_mag;
    logic [7:0]              lon_deg_base;
    logic [7:0]              lon_deg_raw;
    logic [7:0]              lon_deg;
    logic [7:0]              lon_min_raw;
    logic [6:0]              lon_min;
    logic [6:0]              lon_frag;
    logic [LONGITUDE_W-2:0]  lon_deg_part;
    logic [12:0]             lon_min_part;
    logic [6:0]              lon_frag_part;
    logic [LONGITUDE_W-2:0]  lon_mag;

    always_comb
    begin
        lat_deg  = 7'(dinfo.digit[0]) * 7'd10 + 7'(dinfo.digit[1]);
        lat_min  = 7'(dinfo.digit[2]) * 7'd10 + 7'(dinfo.digit[3]);
        lat_frag = 7'(dinfo.digit[4]) * 7'd10 + 7'(dinfo.digit[5]);
        lat_mag  = 20'(lat_deg) * 20'(DEG_SCALE) + 20'(lat_min) * 20'(MIN_SCALE)
                 + 20'(lat_frag);
        latitude = dinfo.south ? -$signed({1'b0, lat_mag}) : $signed({1'b0, lat_mag});
    end

    always_comb
    begin
        lon_deg_base = lon_deg_byte - 8'(CHAR_OFFSET);
        lon_deg_raw  = dinfo.lon_offset ? lon_deg_base + 8'(LON_DEG_OFFSET) : lon_deg_base;
        if ((lon_deg_raw >= 8'(LON_WRAP_A_LO)) && (lon_deg_raw <= 8'(LON_WRAP_A_HI)))
            lon_deg = lon_deg_raw - 8'(LON_WRAP_A_SUB);
        else if ((lon_deg_raw >= 8'(LON_WRAP_B_LO)) && (lon_deg_raw <= 8'(LON_WRAP_B_HI)))
            lon_deg = lon_deg_raw - 8'(LON_WRAP_B_LO);
        else
            lon_deg = lon_deg_raw;

        lon_min_raw = lon_min_byte - 8'(CHAR_OFFSET);
        lon_min     = (lon_min_raw >= 8'(MIN_WRAP)) ? 7'(lon_min_raw - 8'(MIN_WRAP))
                                                    : 7'(lon_min_raw);
        lon_frag    = 7'(lon_frag_byte - 8'(CHAR_OFFSET));

        lon_deg_part = 21'(lon_deg) * 21'(DEG_SCALE);

        case (dinfo.amb)
            AMB_NONE:
            begin
                lon_min_part  = 13'(lon_min) * 13'(MIN_SCALE);
                lon_frag_part = lon_frag;
            end
            AMB_HUNDREDTHS:
            begin
                lon_min_part  = 13'(lon_min) * 13'(MIN_SCALE);
                lon_frag_part = floor10(lon_frag) + 7'd5;
            end
            AMB_TENTHS:
            begin
                lon_min_part  = 13'(lon_min) * 13'(MIN_SCALE);
                lon_frag_part = 7'(HALF_MINUTE);
            end
            AMB_MINUTES:
            begin
                lon_min_part  = 13'(floor10(lon_min) + 7'd5) * 13'(MIN_SCALE);
                lon_frag_part = 7'd0;
            end
            default:
            begin
                lon_min_part  = 13'(HALF_DEGREE);
                lon_frag_part = 7'd0;
            end
        endcase

        lon_mag   = lon_deg_part + 21'(lon_min_part) + 21'(lon_frag_part);
        longitude = dinfo.west ? -$signed({1'b0, lon_mag}) : $signed({1'b0, lon_mag});
    end

endmodule

[hdl/mic_e_position_decoder.sv]
// Mic-E position decoder top level: input register, decode logic, result register.
// An input item is captured in the input register, decoded, and its result is loaded
// into the result register once that stage is empty or being drained.
// Throughput: one item per cycle unless the output stalls; the two-entry pipeline of
// input and result registers takes an item while a finished result waits downstream.
// Reset: rst_n asynchronously clears both valid flags; payload registers are not reset.
module mic_e_position_decoder (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0 up: dest_chars[47:0], dest_length[53:48],
    // info_bytes[117:54], info_length[125:118], zero fill[127:126].
    input  logic [mic_e_pkg::S_TDATA_W-1:0] s_tdata,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0 up: status[2:0], latitude[23:3], longitude[45:24],
    // symbol_code[53:46], symbol_table[61:54], ambiguity[64:62], zero fill[71:65].
    output logic [mic_e_pkg::M_TDATA_W-1:0] m_tdata
);
    import mic_e_pkg::*;

    // Checks the character class of the information bytes; byte 4 is not checked.
    function automatic logic info_ok(input logic [INFO_BYTES_W-1:0] info);
        logic [7:0] b0, b1, b2, b3, b5, b6, b7;
        logic       ok6, ok7;
        b0  = info[63:56];
        b1  = info[55:48];
        b2  = info[47:40];
        b3  = info[39:32];
        b5  = info[23:16];
        b6  = info[15:8];
        b7  = info[7:0];
        ok6 = ((b6 >= 8'h21) && (b6 <= 8'h7b)) || (b6 == 8'h7d);
        ok7 = (b7 == 8'h2f) || (b7 == 8'h5c) || ((b7 >= 8'h41) && (b7 <= 8'h5a))
            || ((b7 >= 8'h30) && (b7 <= 8'h39));
        return (b0 >= 8'h26) && (b0 <= 8'h7f) && (b1 >= 8'h26) && (b1 <= 8'h61)
            && (b2 >= 8'h1c) && (b2 <= 8'h7f) && (b3 >= 8'h1c) && (b3 <= 8'h7f)
            && (b5 >= 8'h1c) && (b5 <= 8'h7f) && ok6 && ok7;
    endfunction

    // Input register: one captured item and its valid flag.
    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic [DEST_CHARS_W-1:0]   dest_chars_reg;
    logic [DEST_LENGTH_W-1:0]  dest_length_reg;
    logic [INFO_BYTES_W-1:0]   info_bytes_reg;
    logic [INFO_LENGTH_W-1:0]  info_length_reg;

    // Result register.
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [M_TDATA_W-1:0]      result_reg;
    logic [M_TDATA_W-1:0]      result_next;

    logic                      out_adv;
    logic                      in_load;

    dest_info_t                      dinfo;
    logic signed [LATITUDE_W-1:0]    lat_val;
    logic signed [LONGITUDE_W-1:0]   lon_val;
    status_t                         status;

    // The result stage can take a new item when it is empty or being drained,
    // and the input stage can take one when it is empty or moving forward.
    assign out_adv  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_adv;
    assign in_load  = s_tvalid && s_tready;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = out_adv ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            dest_chars_reg  <= s_tdata[47:0];
            dest_length_reg <= s_tdata[53:48];
            info_bytes_reg  <= s_tdata[117:54];
            info_length_reg <= s_tdata[125:118];
        end
        if (out_adv && in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    // Destination call analysis: classes, digits, ambiguity and hemispheres.
    mic_e_dest u_dest (
        .dest_chars (dest_chars_reg),
        .dinfo      (dinfo)
    );

    // Coordinates from the digits and the first three information bytes.
    mic_e_coord u_coord (
        .dinfo         (dinfo),
        .lon_deg_byte  (info_bytes_reg[63:56]),
        .lon_min_byte  (info_bytes_reg[55:48]),
        .lon_frag_byte (info_bytes_reg[47:40]),
        .latitude      (lat_val),
        .longitude     (lon_val)
    );

    // Checks are ranked: info length, destination length, destination characters,
    // then information bytes together with a marker in the degree digits.
    always_comb
    begin
        if (info_length_reg < INFO_LENGTH_W'(INFO_MIN_LEN))
            status = ST_SHORT_INFO;
        else if (dest_length_reg != DEST_LENGTH_W'(NUM_DEST_CHARS))
            status = ST_BAD_DEST_LEN;
        else if (!dinfo.chars_ok)
            status = ST_BAD_DEST_CHAR;
        else if (!info_ok(info_bytes_reg) || dinfo.lead_marker)
            status = ST_BAD_INFO;
        else
            status = ST_OK;

        // Any failed check leaves every other result field at zero.
        if (status == ST_OK)
            result_next = {7'd0, dinfo.amb, info_bytes_reg[7:0], info_bytes_reg[15:8],
                           lon_val, lat_val, status};
        else
            result_next = {(M_TDATA_W-STATUS_W)'(0), status};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

    // A failed item carries no position, symbol or ambiguity.
    a_error_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[2:0] != ST_OK)) |-> (m_tdata[M_TDATA_W-1:STATUS_W] == '0))
        else $error("error result carries nonzero fields");

    // Status and ambiguity stay within their defined codes.
    a_codes_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[2:0] <= ST_BAD_INFO) && (m_tdata[64:62] <= AMB_TEN_MIN)))
        else $error("status or ambiguity out of range");

    // An item in the input stage that moves forward shows up as a result.
    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_adv) |=> m_tvalid)
        else $error("item lost between stages");

    // Input is refused only when both stages hold items and the output stalls.
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input refused while pipeline has room");

endmodule

[tb/tb_mic_e_position_decoder.sv]
// Self-checking testbench for the Mic-E position decoder stream block.
module tb_mic_e_position_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import mic_e_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 1830;
    localparam int TAIL_CYCLES   = 20;
    localparam int CYCLE_LIMIT   = 800000;

    // One position report as it enters the block.
    typedef struct packed {
        logic [DEST_CHARS_W-1:0]  dest_chars;
        logic [DEST_LENGTH_W-1:0] dest_length;
        logic [INFO_BYTES_W-1:0]  info_bytes;
        logic [INFO_LENGTH_W-1:0] info_length;
    } report_t;

    // One decoded fix as it leaves the block.
    typedef struct packed {
        status_t                        status;
        logic signed [LATITUDE_W-1:0]   latitude;
        logic signed [LONGITUDE_W-1:0]  longitude;
        logic [SYMBOL_W-1:0]            symbol_code;
        logic [SYMBOL_W-1:0]            symbol_table;
        logic [AMBIGUITY_W-1:0]         ambiguity;
    } fix_t;

    // A directed row: the report, and for error rows the status typed in by hand.
    typedef struct {
        report_t rpt;
        bit      typed;
        status_t status;
    } probe_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;

    fix_t        pending_fixes[$];
    probe_t      probes[$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned cycles = 0;
    int unsigned stall_left = 0;

    mic_e_position_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic bit in_range(logic [7:0] c, logic [7:0] lo, logic [7:0] hi);
        return c >= lo && c <= hi;
    endfunction

    // Independent decode of one report into the fix the block must produce.
    function automatic fix_t decode_position(report_t r);
        logic [7:0]      d [6];
        logic [7:0]      b [8];
        int              dig [6];
        logic [2:0]      amb;
        bit              ok;
        int              lat, lng, lng_deg, lng_min, lng_frag;
        fix_t            f;
        f = '0;
        f.status = ST_OK;
        amb = AMB_NONE;
        for (int i = 0; i < 6; i++) d[i] = r.dest_chars[8*(5-i) +: 8];
        for (int i = 0; i < 8; i++) b[i] = r.info_bytes[8*(7-i) +: 8];

        if (r.info_length < INFO_MIN_LEN)
        begin
            f.status = ST_SHORT_INFO;
            return f;
        end
        if (r.dest_length != NUM_DEST_CHARS)
        begin
            f.status = ST_BAD_DEST_LEN;
            return f;
        end
        for (int i = 0; i < 6; i++)
        begin
            if (i < 3)
                ok = in_range(d[i], "0", "9") || in_range(d[i], "A", "L")
                     || in_range(d[i], "P", "Z");
            else
                ok = in_range(d[i], "0", "9") || d[i] == "L" || in_range(d[i], "P", "Z");
            if (!ok)
            begin
                f.status = ST_BAD_DEST_CHAR;
                return f;
            end
        end
        if (!in_range(b[0], 8'h26, 8'h7f) || !in_range(b[1], 8'h26, 8'h61) ||
            !in_range(b[2], 8'h1c, 8'h7f) || !in_range(b[3], 8'h1c, 8'h7f) ||
            !in_range(b[5], 8'h1c, 8'h7f) ||
            (!in_range(b[6], 8'h21, 8'h7b) && b[6] != 8'h7d) ||
            !(b[7] == "/" || b[7] == "\\" || in_range(b[7], "A", "Z") ||
              in_range(b[7], "0", "9")))
        begin
            f.status = ST_BAD_INFO;
            return f;
        end

        // Letters A-J and P-Y stand for digits; K, L and Z are ambiguity markers.
        for (int i = 0; i < 6; i++)
        begin
            if (in_range(d[i], "A", "J"))      dig[i] = int'(d[i] - "A");
            else if (in_range(d[i], "P", "Y")) dig[i] = int'(d[i] - "P");
            else if (in_range(d[i], "0", "9")) dig[i] = int'(d[i] - "0");
            else                               dig[i] = DIGIT_MARKER;
        end
        // The leftmost marker wins, so walk from the right.
        if (dig[5] == DIGIT_MARKER)
        begin
            dig[5] = 5;
            amb = AMB_HUNDREDTHS;
        end
        if (dig[4] == DIGIT_MARKER)
        begin
            dig[4] = 5;
            amb = AMB_TENTHS;
        end
        if (dig[3] == DIGIT_MARKER)
        begin
            dig[3] = 5;
            amb = AMB_MINUTES;
        end
        if (dig[2] == DIGIT_MARKER)
        begin
            dig[2] = 3;
            amb = AMB_TEN_MIN;
        end
        if (dig[0] == DIGIT_MARKER || dig[1] == DIGIT_MARKER)
        begin
            f.status = ST_BAD_INFO;
            return f;
        end

        lat = (dig[0] * 10 + dig[1]) * DEG_SCALE + (dig[2] * 10 + dig[3]) * MIN_SCALE
              + dig[4] * 10 + dig[5];

        lng_deg = int'(b[0]) - CHAR_OFFSET;
        if (d[4] >= CH_NORTH_MIN) lng_deg += LON_DEG_OFFSET;
        if (lng_deg >= LON_WRAP_A_LO && lng_deg <= LON_WRAP_A_HI)
            lng_deg -= LON_WRAP_A_SUB;
        else if (lng_deg >= LON_WRAP_B_LO && lng_deg <= LON_WRAP_B_HI)
            lng_deg -= LON_WRAP_B_LO;
        lng_min = int'(b[1]) - CHAR_OFFSET;
        if (lng_min >= MIN_WRAP) lng_min -= MIN_WRAP;
        lng_frag = int'(b[2]) - CHAR_OFFSET;

        case (amb)
            AMB_NONE:
                lng = lng_deg * DEG_SCALE + lng_min * MIN_SCALE + lng_frag;
            AMB_HUNDREDTHS:
                lng = lng_deg * DEG_SCALE + lng_min * MIN_SCALE + lng_frag - lng_frag % 10 + 5;
            AMB_TENTHS:
                lng = lng_deg * DEG_SCALE + lng_min * MIN_SCALE + HALF_MINUTE;
            AMB_MINUTES:
                lng = lng_deg * DEG_SCALE + (lng_min - lng_min % 10 + 5) * MIN_SCALE;
            default:
                lng = lng_deg * DEG_SCALE + HALF_DEGREE;
        endcase

        f.latitude     = LATITUDE_W'(d[3] <= CH_SOUTH_MAX ? -lat : lat);
        f.longitude    = LONGITUDE_W'(d[5] >= CH_NORTH_MIN ? -lng : lng);
        f.symbol_code  = b[6];
        f.symbol_table = b[7];
        f.ambiguity    = amb;
        return f;
    endfunction

    function automatic probe_t row(logic [47:0] dest, logic [5:0] dlen, logic [63:0] info,
                                   logic [7:0] ilen, bit typed, status_t st);
        probe_t p;
        p.rpt    = '{dest, dlen, info, ilen};
        p.typed  = typed;
        p.status = st;
        return p;
    endfunction

    // A valid destination character for a column, or a marker if asked for.
    function automatic logic [7:0] pick_dest_char(int pos, bit marker);
        if (marker)
        begin
            if (pos >= 3) return $urandom_range(0, 1) ? "L" : "Z";
            case ($urandom_range(0, 2))
                0:       return "K";
                1:       return "L";
                default: return "Z";
            endcase
        end
        case ($urandom_range(0, pos < 3 ? 2 : 1))
            0:       return "0" + 8'($urandom_range(0, 9));
            1:       return "P" + 8'($urandom_range(0, 9));
            default: return "A" + 8'($urandom_range(0, 9));
        endcase
    endfunction

    // Mostly well-formed reports with random content, some broken ones, some noise.
    function automatic report_t random_report();
        report_t    r;
        logic [7:0] b [8];
        int         mode, p, v;
        mode = $urandom_range(0, 99);
        if (mode < 10)
        begin
            r.dest_chars  = 48'({$urandom, $urandom});
            r.dest_length = 6'($urandom);
            r.info_bytes  = {$urandom, $urandom};
            r.info_length = 8'($urandom);
            return r;
        end
        for (int i = 0; i < 6; i++)
            r.dest_chars[8*(5-i) +: 8] = pick_dest_char(i, i >= 2 && $urandom_range(0, 4) == 0);
        b[0] = 8'($urandom_range(8'h26, 8'h7f));
        b[1] = 8'($urandom_range(8'h26, 8'h61));
        b[2] = 8'($urandom_range(8'h1c, 8'h7f));
        b[3] = 8'($urandom_range(8'h1c, 8'h7f));
        b[4] = 8'($urandom);
        b[5] = 8'($urandom_range(8'h1c, 8'h7f));
        b[6] = ($urandom_range(0, 15) == 0) ? 8'h7d : 8'($urandom_range(8'h21, 8'h7b));
        case ($urandom_range(0, 3))
            0:       b[7] = "/";
            1:       b[7] = "\\";
            2:       b[7] = "A" + 8'($urandom_range(0, 25));
            default: b[7] = "0" + 8'($urandom_range(0, 9));
        endcase
        r.info_bytes  = {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
        r.dest_length = 6'(NUM_DEST_CHARS);
        r.info_length = 8'($urandom_range(INFO_MIN_LEN, 255));
        if (mode >= 85)
        begin
            // Disturb exactly one aspect of an otherwise good report.
            case ($urandom_range(0, 5))
                0: r.info_length = 8'($urandom_range(0, INFO_MIN_LEN - 1));
                1:
                begin
                    v = $urandom_range(0, 62);
                    r.dest_length = 6'(v >= NUM_DEST_CHARS ? v + 1 : v);
                end
                2:
                begin
                    p = $urandom_range(0, 5);
                    r.dest_chars[8*(5-p) +: 8] = 8'($urandom);
                end
                3:
                begin
                    p = $urandom_range(0, 7);
                    r.info_bytes[8*(7-p) +: 8] = 8'($urandom);
                end
                4:
                begin
                    p = $urandom_range(0, 1);
                    r.dest_chars[8*(5-p) +: 8] = pick_dest_char(p, 1'b1);
                end
                default:
                begin
                    p = $urandom_range(3, 5);
                    r.dest_chars[8*(5-p) +: 8] = "A" + 8'($urandom_range(0, 10));
                end
            endcase
        end
        return r;
    endfunction

    // Idle cycles before an item: long quiet stretches with no gaps at all.
    function automatic int pick_gap(int idx);
        int roll;
        if ((idx / 150) % 4 == 3) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic signed [63:0] got,
                               logic signed [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                      results_seen, name, got, want));
    endtask

    // Offers one item after a random gap and records its expected fix once taken.
    task automatic send_report(report_t r, fix_t want, int idx);
        int gap;
        gap = pick_gap(idx);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, r.info_length, r.info_bytes, r.dest_length, r.dest_chars};
        do @(posedge clk); while (!s_tready);
        pending_fixes.push_back(want);
    endtask

    // Holds the sender off until every pending fix has come out.
    task automatic drain_pending();
        s_tvalid <= 1'b0;
        while (pending_fixes.size() != 0) @(posedge clk);
    endtask

    // The receiver stalls at random, with calm stretches where it never stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ((cycles / 2500) % 4 == 1 || $urandom_range(0, 99) < 70)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            m_tready   <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 3);
        end
    end

    // Every accepted result is compared with the oldest pending fix.
    always @(posedge clk)
    begin : result_check
        fix_t got;
        fix_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status       = status_t'(m_tdata[2:0]);
            got.latitude     = m_tdata[23:3];
            got.longitude    = m_tdata[45:24];
            got.symbol_code  = m_tdata[53:46];
            got.symbol_table = m_tdata[61:54];
            got.ambiguity    = m_tdata[64:62];
            if (pending_fixes.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with no item pending",
                                          results_seen));
            end
            else
            begin
                want = pending_fixes.pop_front();
                check_field("status", got.status, want.status);
                check_field("latitude", got.latitude, want.latitude);
                check_field("longitude", got.longitude, want.longitude);
                check_field("symbol_code", got.symbol_code, want.symbol_code);
                check_field("symbol_table", got.symbol_table, want.symbol_table);
                check_field("ambiguity", got.ambiguity, want.ambiguity);
            end
            results_seen++;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d fixes pending",
                     cycles, pending_fixes.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        fix_t        want;
        logic [63:0] good_info;
        good_info = 64'h7a_5b_40_1c_ff_30_3e_2f;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;

        // Length and class errors: result fields are all zero, status typed in.
        probes.push_back(row("A9P3TX", 6'd6, good_info, 8'd0, 1, ST_SHORT_INFO));
        probes.push_back(row("A9P3TX", 6'd6, good_info, 8'd7, 1, ST_SHORT_INFO));
        probes.push_back(row("A9P3TX", 6'd0, good_info, 8'd8, 1, ST_BAD_DEST_LEN));
        probes.push_back(row("A9P3TX", 6'd63, good_info, 8'd255, 1, ST_BAD_DEST_LEN));
        probes.push_back(row("a9P3TX", 6'd6, good_info, 8'd8, 1, ST_BAD_DEST_CHAR));
        probes.push_back(row("A9M3TX", 6'd6, good_info, 8'd8, 1, ST_BAD_DEST_CHAR));
        probes.push_back(row("A9P3AX", 6'd6, good_info, 8'd8, 1, ST_BAD_DEST_CHAR));
        probes.push_back(row({"A9P3T", 8'hff}, 6'd6, good_info, 8'd8, 1, ST_BAD_DEST_CHAR));
        probes.push_back(row("A9P3TX", 6'd6, 64'h25_5b_40_1c_ff_30_3e_2f, 8'd8, 1, ST_BAD_INFO));
        probes.push_back(row("A9P3TX", 6'd6, 64'h80_5b_40_1c_ff_30_3e_2f, 8'd8, 1, ST_BAD_INFO));
        probes.push_back(row("A9P3TX", 6'd6, 64'h7a_62_40_1c_ff_30_3e_2f, 8'd8, 1, ST_BAD_INFO));
        probes.push_back(row("A9P3TX", 6'd6, 64'h7a_5b_1b_1c_ff_30_3e_2f, 8'd8, 1, ST_BAD_INFO));
        probes.push_back(row("A9P3TX", 6'd6, 64'h7a_5b_40_1c_ff_30_7c_2f, 8'd8, 1, ST_BAD_INFO));
        probes.push_back(row("A9P3TX", 6'd6, 64'h7a_5b_40_1c_ff_30_3e_61, 8'd8, 1, ST_BAD_INFO));
        // A marker in the first two columns is an ambiguity error.
        probes.push_back(row("KP3RTX", 6'd6, good_info, 8'd8, 1, ST_BAD_INFO));
        probes.push_back(row("AZ3RTX", 6'd6, good_info, 8'd8, 1, ST_BAD_INFO));
        // Field extremes and every ambiguity level, checked against the predictor.
        probes.push_back(row("000000", 6'd6, 64'h26_26_1c_1c_00_1c_21_30, 8'd8, 0, ST_OK));
        probes.push_back(row("YYYYYY", 6'd6, 64'h7f_61_7f_7f_ff_7f_7d_5c, 8'd255, 0, ST_OK));
        probes.push_back(row("PPPPPZ", 6'd6, good_info, 8'd8, 0, ST_OK));
        probes.push_back(row("PPPPLP", 6'd6, good_info, 8'd8, 0, ST_OK));
        probes.push_back(row("PPPZPP", 6'd6, good_info, 8'd8, 0, ST_OK));
        probes.push_back(row("PPKPPP", 6'd6, good_info, 8'd8, 0, ST_OK));
        probes.push_back(row("JJZLLZ", 6'd6, 64'h26_5c_7f_1c_00_1c_41_5a, 8'd9, 0, ST_OK));
        // The lower longitude wrap region of the degree byte, and minute wrap.
        probes.push_back(row("PPPPPP", 6'd6, 64'h70_5c_50_20_12_40_7b_39, 8'd8, 0, ST_OK));
        probes.push_back(row("0P0P0P", 6'd6, 64'h7a_61_63_7f_80_7f_21_41, 8'd8, 0, ST_OK));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probes[i])
        begin
            if (probes[i].typed)
            begin
                want = '0;
                want.status = probes[i].status;
            end
            else
            begin
                want = decode_position(probes[i].rpt);
            end
            send_report(probes[i].rpt, want, i);
        end
        drain_pending();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            report_t r;
            r = random_report();
            send_report(r, decode_position(r), i);
            if (i == RANDOM_ITEMS / 2) drain_pending();
        end
        s_tvalid <= 1'b0;

        while (pending_fixes.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[mic_e_position_decoder.f]
hdl/mic_e_pkg.sv
hdl/mic_e_dest.sv
hdl/mic_e_coord.sv
hdl/mic_e_position_decoder.sv
tb/tb_mic_e_position_decoder.sv
